FILE: sv/rth_pkg.sv
// rth_pkg: shared types, constants and the divider step for the rgb_to_hsv pipeline
// depends on nothing; every rth_* module and the top level use it by scoped names
package rth_pkg;

	localparam int HueFracBits = 6;
	localparam int ChanW = 8;
	localparam int HueW = 15;
	localparam int SatW = 9;

	localparam int Deg60 = 60 << HueFracBits;
	localparam int Deg120 = 120 << HueFracBits;
	localparam int Deg240 = 240 << HueFracBits;
	localparam int Deg360 = 360 << HueFracBits;

	// quotient width covers both the hue term and the Q1.8 saturation
	localparam int QuoRawW = $clog2(Deg60 + 1);
	localparam int QuoW = (QuoRawW > SatW) ? QuoRawW : SatW;
	localparam int NumW = QuoW + ChanW;

	// hue sum width, never narrower than the field
	localparam int HueRawW = $clog2(Deg360 + 1);
	localparam int HueSumW = (HueRawW > HueW) ? HueRawW : HueW;

	localparam int DivBitsPerStage = 3;
	localparam int DivStages = (QuoW + DivBitsPerStage - 1) / DivBitsPerStage;

	typedef enum logic [1:0] {
		SEC_RED,
		SEC_GREEN,
		SEC_BLUE
	} sector_t;

	// what rides along with an item while its divisions run
	typedef struct packed {
		logic [ChanW-1:0] mx;
		logic             neg;
		sector_t          sector;
		logic             gray;
	} ctx_t;

	typedef struct packed {
		ctx_t             ctx;
		logic [ChanW-1:0] delta;
		logic [ChanW-1:0] mag;
	} sort_t;

	typedef struct packed {
		logic [ChanW-1:0] rem;
		logic [QuoW-1:0]  low;
		logic [QuoW-1:0]  q;
	} div_t;

	typedef struct packed {
		ctx_t             ctx;
		logic [ChanW-1:0] sat_d;
		logic [ChanW-1:0] hue_d;
		div_t             sat;
		div_t             hue;
	} dv_t;

	// start a restoring division; the quotient is known to fit in QuoW bits
	function automatic div_t div_init(logic [NumW-1:0] num);
		div_t y;
		y.rem = num[NumW-1:QuoW];
		y.low = num[QuoW-1:0];
		y.q = '0;
		return y;
	endfunction

	// one quotient bit: shift in the next dividend bit, subtract if it fits
	function automatic div_t div_step(div_t x, logic [ChanW-1:0] d);
		logic [ChanW:0] t;
		div_t y;
		t = {x.rem, x.low[QuoW-1]};
		y.low = {x.low[QuoW-2:0], 1'b0};
		if (t >= {1'b0, d}) begin
			y.rem = ChanW'(t - {1'b0, d});
			y.q = {x.q[QuoW-2:0], 1'b1};
		end else begin
			y.rem = t[ChanW-1:0];
			y.q = {x.q[QuoW-2:0], 1'b0};
		end
		return y;
	endfunction

endpackage

FILE: sv/rth_sort.sv
// rth_sort: first pipeline stage, finds max, min, delta, sector and the signed diff
// depends on rth_pkg
module rth_sort (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      up_valid,
	output logic                      up_ready,
	input  logic [rth_pkg::ChanW-1:0] red,
	input  logic [rth_pkg::ChanW-1:0] green,
	input  logic [rth_pkg::ChanW-1:0] blue,
	output logic                      dn_valid,
	input  logic                      dn_ready,
	output rth_pkg::sort_t            dn_data
);

	logic                      valid_s1;
	rth_pkg::sort_t            sort_s1;
	rth_pkg::sort_t            sort_d;
	logic [rth_pkg::ChanW-1:0] mx;
	logic [rth_pkg::ChanW-1:0] mn;
	logic [rth_pkg::ChanW-1:0] a;
	logic [rth_pkg::ChanW-1:0] b;

	always_comb begin
		mx = red;
		mn = red;
		if (green > mx) mx = green;
		if (blue > mx) mx = blue;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;

		// diff = a - b in the sector picked by priority
		if (red >= mx) begin
			a = green;
			b = blue;
			sort_d.ctx.sector = rth_pkg::SEC_RED;
		end else if (green >= mx) begin
			a = blue;
			b = red;
			sort_d.ctx.sector = rth_pkg::SEC_GREEN;
		end else begin
			a = red;
			b = green;
			sort_d.ctx.sector = rth_pkg::SEC_BLUE;
		end

		sort_d.ctx.mx = mx;
		sort_d.ctx.neg = (a < b);
		sort_d.ctx.gray = (mx == mn);
		sort_d.delta = mx - mn;
		sort_d.mag = (a < b) ? (b - a) : (a - b);
	end

	assign up_ready = !valid_s1 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			sort_s1 <= sort_d;
		end
	end

	assign dn_valid = valid_s1;
	assign dn_data = sort_s1;

endmodule

FILE: sv/rth_mul.sv
// rth_mul: second stage, scales the hue diff and forms both dividends
// depends on rth_pkg
module rth_mul (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           up_valid,
	output logic           up_ready,
	input  rth_pkg::sort_t up_data,
	output logic           dn_valid,
	input  logic           dn_ready,
	output rth_pkg::dv_t   dn_data
);

	logic                     valid_s2;
	rth_pkg::dv_t             dv_s2;
	rth_pkg::dv_t             dv_d;
	logic [rth_pkg::NumW-1:0] hue_num;
	logic [rth_pkg::NumW-1:0] sat_num;

	always_comb begin
		hue_num = rth_pkg::NumW'(up_data.mag) * rth_pkg::NumW'(rth_pkg::Deg60);
		// delta * 256 for the Q1.8 ratio
		sat_num = rth_pkg::NumW'(up_data.delta) << (rth_pkg::SatW - 1);
		dv_d.ctx = up_data.ctx;
		dv_d.sat_d = up_data.ctx.mx;
		dv_d.hue_d = up_data.delta;
		dv_d.sat = rth_pkg::div_init(sat_num);
		dv_d.hue = rth_pkg::div_init(hue_num);
	end

	assign up_ready = !valid_s2 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (up_ready) begin
			valid_s2 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			dv_s2 <= dv_d;
		end
	end

	assign dn_valid = valid_s2;
	assign dn_data = dv_s2;

endmodule

FILE: sv/rth_div.sv
// rth_div: pipelined restoring divider, saturation and hue quotients side by side
// depends on rth_pkg (div_step, stage count and bits per stage)
module rth_div (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         up_valid,
	output logic         up_ready,
	input  rth_pkg::dv_t up_data,
	output logic         dn_valid,
	input  logic         dn_ready,
	output rth_pkg::dv_t dn_data
);

	logic [rth_pkg::DivStages-1:0] vld_s;
	rth_pkg::dv_t                  dv_s [rth_pkg::DivStages];
	logic [rth_pkg::DivStages:0]   rdy;

	assign rdy[rth_pkg::DivStages] = dn_ready;
	assign up_ready = rdy[0];

	for (genvar k = 0; k < rth_pkg::DivStages; k++) begin : g_stage
		rth_pkg::dv_t prev;
		rth_pkg::dv_t nxt;
		logic         prev_vld;

		if (k == 0) begin : g_first
			assign prev = up_data;
			assign prev_vld = up_valid;
		end else begin : g_rest
			assign prev = dv_s[k-1];
			assign prev_vld = vld_s[k-1];
		end

		assign rdy[k] = !vld_s[k] || rdy[k+1];

		always_comb begin
			nxt = prev;
			for (int j = 0; j < rth_pkg::DivBitsPerStage; j++) begin
				// the last stage may have fewer bits left to produce
				if (k * rth_pkg::DivBitsPerStage + j < rth_pkg::QuoW) begin
					nxt.sat = rth_pkg::div_step(nxt.sat, prev.sat_d);
					nxt.hue = rth_pkg::div_step(nxt.hue, prev.hue_d);
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld_s[k] <= prev_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && prev_vld) begin
				dv_s[k] <= nxt;
			end
		end
	end

	assign dn_valid = vld_s[rth_pkg::DivStages-1];
	assign dn_data = dv_s[rth_pkg::DivStages-1];

endmodule

FILE: sv/rth_hue.sv
// rth_hue: last stage, adds the sector offset, wraps negative hue, output register
// depends on rth_pkg
module rth_hue (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      up_valid,
	output logic                      up_ready,
	input  rth_pkg::dv_t              up_data,
	output logic                      dn_valid,
	input  logic                      dn_ready,
	output logic [rth_pkg::HueW-1:0]  hue,
	output logic [rth_pkg::SatW-1:0]  saturation,
	output logic [rth_pkg::ChanW-1:0] brightness
);

	logic                        valid_s7;
	logic [rth_pkg::HueW-1:0]    hue_s7;
	logic [rth_pkg::SatW-1:0]    sat_s7;
	logic [rth_pkg::ChanW-1:0]   val_s7;
	logic [rth_pkg::HueSumW-1:0] term;
	logic [rth_pkg::HueSumW-1:0] sum;
	logic [rth_pkg::HueW-1:0]    hue_d;
	logic [rth_pkg::SatW-1:0]    sat_d;

	always_comb begin
		term = rth_pkg::HueSumW'(up_data.hue.q);
		case (up_data.ctx.sector)
			rth_pkg::SEC_GREEN: begin
				sum = up_data.ctx.neg ? rth_pkg::HueSumW'(rth_pkg::Deg120) - term
					: rth_pkg::HueSumW'(rth_pkg::Deg120) + term;
			end
			rth_pkg::SEC_BLUE: begin
				sum = up_data.ctx.neg ? rth_pkg::HueSumW'(rth_pkg::Deg240) - term
					: rth_pkg::HueSumW'(rth_pkg::Deg240) + term;
			end
			default: begin
				// a term that truncates to zero gets no wrap
				if (up_data.ctx.neg && term != '0) begin
					sum = rth_pkg::HueSumW'(rth_pkg::Deg360) - term;
				end else begin
					sum = term;
				end
			end
		endcase

		if (up_data.ctx.gray) begin
			hue_d = '0;
			sat_d = '0;
		end else begin
			hue_d = sum[rth_pkg::HueW-1:0];
			sat_d = up_data.sat.q[rth_pkg::SatW-1:0];
		end
	end

	assign up_ready = !valid_s7 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
		end else if (up_ready) begin
			valid_s7 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			hue_s7 <= hue_d;
			sat_s7 <= sat_d;
			val_s7 <= up_data.ctx.mx;
		end
	end

	assign dn_valid = valid_s7;
	assign hue = hue_s7;
	assign saturation = sat_s7;
	assign brightness = val_s7;

endmodule

FILE: sv/rgb_to_hsv.sv
// rgb_to_hsv: top level, pixel in, hue / saturation / value out
// depends on rth_pkg, rth_sort, rth_mul, rth_div, rth_hue
//
// channel  signals                         direction  meaning
// pix      pix_valid pix_stall red green blue  in     one 8-bit rgb pixel
// hsv      hsv_valid hsv_stall hue saturation brightness  out  hue, Q1.8 sat, max
//
// one item per cycle while hsv is not stalled; items are registered in rth_sort, rth_mul,
// each rth_div stage (three quotient bits per stage) and rth_hue
// reset clears the stage valid bits only; there is no clearing pass
// each stage holds while the next is full and stalled, and empty stages fill up,
// so pix_stall rises only when every stage holds an item and hsv is stalled
module rgb_to_hsv (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      pix_valid,
	output logic                      pix_stall,
	input  logic [rth_pkg::ChanW-1:0] red,
	input  logic [rth_pkg::ChanW-1:0] green,
	input  logic [rth_pkg::ChanW-1:0] blue,
	output logic                      hsv_valid,
	input  logic                      hsv_stall,
	output logic [rth_pkg::HueW-1:0]  hue,
	output logic [rth_pkg::SatW-1:0]  saturation,
	output logic [rth_pkg::ChanW-1:0] brightness
);

	logic           pix_ready;
	logic           sort_valid;
	logic           sort_ready;
	rth_pkg::sort_t sort_data;
	logic           mul_valid;
	logic           mul_ready;
	rth_pkg::dv_t   mul_data;
	logic           div_valid;
	logic           div_ready;
	rth_pkg::dv_t   div_data;

	assign pix_stall = !pix_ready;

	rth_sort u_sort (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (pix_valid),
		.up_ready (pix_ready),
		.red      (red),
		.green    (green),
		.blue     (blue),
		.dn_valid (sort_valid),
		.dn_ready (sort_ready),
		.dn_data  (sort_data)
	);

	rth_mul u_mul (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (sort_valid),
		.up_ready (sort_ready),
		.up_data  (sort_data),
		.dn_valid (mul_valid),
		.dn_ready (mul_ready),
		.dn_data  (mul_data)
	);

	rth_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (mul_valid),
		.up_ready (mul_ready),
		.up_data  (mul_data),
		.dn_valid (div_valid),
		.dn_ready (div_ready),
		.dn_data  (div_data)
	);

	rth_hue u_hue (
		.clk        (clk),
		.arst_n     (arst_n),
		.up_valid   (div_valid),
		.up_ready   (div_ready),
		.up_data    (div_data),
		.dn_valid   (hsv_valid),
		.dn_ready   (!hsv_stall),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness)
	);

endmodule
